/* hw/rtl/lmwm_pkg.sv */
// Shared types and constants of the label masked window mean core.
package lmwm_pkg;

  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned REG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 4 * CH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [REG_W-1:0] RESET_HEIGHT = 11'd480;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CTR  = 7'b0000010,
    S_LAB  = 7'b0000100,
    S_SCAN = 7'b0001000,
    S_TAIL = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic accept;
    logic ctr_rd;
    logic lab_load;
    logic scan;
    logic div_step;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic res_due;
    logic scan_last;
    logic div_last;
  } sts_t;

endpackage

/* hw/rtl/lmwm_if.sv */
// Stream interfaces for the pixel input beats and the mean result beats.
interface lmwm_pix_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  logic [7:0] segment_label;
  modport source (output valid, operation, blue_in, green_in, red_in, segment_label,
                  input ready);
  modport sink (input valid, operation, blue_in, green_in, red_in, segment_label,
                output ready);
endinterface

interface lmwm_mean_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_mean;
  logic [7:0] green_mean;
  logic [7:0] red_mean;
  logic       frame_last;
  modport source (output valid, blue_mean, green_mean, red_mean, frame_last, input ready);
  modport sink (input valid, blue_mean, green_mean, red_mean, frame_last, output ready);
endinterface

/* hw/rtl/lmwm_ram.sv */
// Generic single-port RAM with registered read data.
module lmwm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* hw/rtl/lmwm_ctrl.sv */
// Controller state machine sequencing accept, window scan, division and output.
module lmwm_ctrl import lmwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.res_due) begin
          state_d = S_CTR;
        end
      end
      S_CTR: begin
        cmd_o.ctr_rd = 1'b1;
        state_d      = S_LAB;
      end
      S_LAB: begin
        cmd_o.lab_load = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

/* hw/rtl/lmwm_dp.sv */
// Datapath: stream position, line store, masked window accumulation and serial divider.
module lmwm_dp import lmwm_pkg::*; #(
  parameter int unsigned MaxWidth = 1024,
  parameter int unsigned Radius   = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 op_i,
  input  logic [PIX_W-1:0]     pix_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic [CH_W-1:0]      blue_o,
  output logic [CH_W-1:0]      green_o,
  output logic [CH_W-1:0]      red_o,
  output logic                 last_o
);
  localparam int unsigned Win      = 2 * Radius + 1;
  localparam int unsigned WinW     = $clog2(Win);
  // On narrow frames the newest pixel runs up to Radius rows past the window's last row.
  localparam int unsigned Slots    = Win + Radius;
  localparam int unsigned SlotIdxW = $clog2(Slots);
  localparam int unsigned SlotW    = SlotIdxW + 2;
  localparam int unsigned ColW     = $clog2(MaxWidth + 1);
  localparam int unsigned CntW     = $clog2(Win * Win + 1);
  localparam int unsigned SumW     = $clog2(Win * Win * 255 + 1);
  localparam int unsigned StepW    = $clog2(SumW);
  localparam int unsigned Depth    = Slots * MaxWidth;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned PosW     = $clog2(MaxWidth * (MAX_HEIGHT + Radius) + Radius + 1);

  logic [REG_W-1:0] width_q, height_q;
  logic [ColW-1:0]  w;
  logic [ROW_W-1:0] h;
  logic [PosW-1:0]  total, lag, centre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w = ColW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      w = ColW'(MaxWidth);
    end else begin
      w = ColW'(width_q);
    end
    if (height_q == '0) begin
      h = ROW_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h = ROW_W'(MAX_HEIGHT);
    end else begin
      h = height_q;
    end
    total = PosW'(w) * PosW'(h);
    lag   = PosW'(w) * PosW'(Radius) + PosW'(Radius);
  end

  // Stream position and write location of the next item.
  logic [PosW-1:0]     pos_q;
  logic [ColW-1:0]     wr_col_q;
  logic [SlotIdxW-1:0] wr_slot_q;
  logic [ColW-1:0]     cen_col_q;
  logic [ROW_W-1:0]    cen_row_q;
  logic [SlotIdxW-1:0] cen_slot_q;
  logic                last_q;
  logic                done, ignore, due_raw, over, is_last, proceed;

  assign centre  = pos_q - lag;
  assign done    = pos_q >= total;
  assign ignore  = (op_i == OP_FLUSH) ? !done : done;
  assign due_raw = pos_q >= lag;
  assign over    = centre >= total;
  assign is_last = centre == total - PosW'(1);
  assign proceed = cmd_i.accept && !ignore;
  assign sts_o.res_due = !ignore && due_raw && !over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      wr_col_q   <= '0;
      wr_slot_q  <= '0;
      cen_col_q  <= '0;
      cen_row_q  <= '0;
      cen_slot_q <= '0;
      last_q     <= 1'b0;
    end else if (cfg_we_i) begin
      pos_q      <= '0;
      wr_col_q   <= '0;
      wr_slot_q  <= '0;
      cen_col_q  <= '0;
      cen_row_q  <= '0;
      cen_slot_q <= '0;
    end else if (proceed) begin
      last_q <= due_raw && is_last;
      if (due_raw && (over || is_last)) begin
        pos_q     <= '0;
        wr_col_q  <= '0;
        wr_slot_q <= '0;
        if (over) begin
          cen_col_q  <= '0;
          cen_row_q  <= '0;
          cen_slot_q <= '0;
        end
      end else begin
        pos_q <= pos_q + PosW'(1);
        if (wr_col_q + ColW'(1) == w) begin
          wr_col_q  <= '0;
          wr_slot_q <= (wr_slot_q == SlotIdxW'(Slots - 1)) ? '0 : wr_slot_q + SlotIdxW'(1);
        end else begin
          wr_col_q <= wr_col_q + ColW'(1);
        end
      end
    end else if (cmd_i.advance) begin
      if (last_q) begin
        cen_col_q  <= '0;
        cen_row_q  <= '0;
        cen_slot_q <= '0;
      end else if (cen_col_q + ColW'(1) == w) begin
        cen_col_q  <= '0;
        cen_row_q  <= cen_row_q + ROW_W'(1);
        cen_slot_q <= (cen_slot_q == SlotIdxW'(Slots - 1)) ? '0 : cen_slot_q + SlotIdxW'(1);
      end else begin
        cen_col_q <= cen_col_q + ColW'(1);
      end
    end
  end

  // Window scan addressing.
  logic [WinW-1:0]     dr_q, dc_q;
  logic [SlotW-1:0]    slot_sum;
  logic [SlotIdxW-1:0] slot;
  logic [ROW_W:0]      row_sum;
  logic [ColW:0]       col_sum;
  logic [ColW-1:0]     col;
  logic                in_bounds;
  logic [AddrW-1:0]    scan_addr, ctr_addr, wr_addr, addr;
  logic [PIX_W-1:0]    rdata;
  logic                rd_valid_q;

  always_comb begin
    slot_sum = SlotW'(cen_slot_q) + SlotW'(dr_q) + SlotW'(Slots - Radius);
    if (slot_sum >= SlotW'(2 * Slots)) begin
      slot = SlotIdxW'(slot_sum - SlotW'(2 * Slots));
    end else if (slot_sum >= SlotW'(Slots)) begin
      slot = SlotIdxW'(slot_sum - SlotW'(Slots));
    end else begin
      slot = SlotIdxW'(slot_sum);
    end
    row_sum   = (ROW_W + 1)'(cen_row_q) + (ROW_W + 1)'(dr_q);
    col_sum   = (ColW + 1)'(cen_col_q) + (ColW + 1)'(dc_q);
    col       = ColW'(col_sum - (ColW + 1)'(Radius));
    in_bounds = (row_sum >= (ROW_W + 1)'(Radius))
             && (row_sum < (ROW_W + 1)'(h) + (ROW_W + 1)'(Radius))
             && (col_sum >= (ColW + 1)'(Radius))
             && (col_sum < (ColW + 1)'(w) + (ColW + 1)'(Radius));
    scan_addr = AddrW'(slot) * AddrW'(MaxWidth) + AddrW'(col);
    ctr_addr  = AddrW'(cen_slot_q) * AddrW'(MaxWidth) + AddrW'(cen_col_q);
    wr_addr   = AddrW'(wr_slot_q) * AddrW'(MaxWidth) + AddrW'(wr_col_q);
    if (cmd_i.scan) begin
      addr = scan_addr;
    end else if (cmd_i.ctr_rd) begin
      addr = ctr_addr;
    end else begin
      addr = wr_addr;
    end
  end

  assign sts_o.scan_last = (dr_q == WinW'(Win - 1)) && (dc_q == WinW'(Win - 1));

  lmwm_ram #(.Width(PIX_W), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (proceed && (op_i == OP_DATA)),
    .addr_i  (addr),
    .wdata_i (pix_i),
    .rdata_o (rdata)
  );

  // Accumulation and restoring division, all three channels in parallel.
  logic [CH_W-1:0]  label_q;
  logic [SumW-1:0]  sb_q, sg_q, sr_q;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  rb_q, rg_q, rr_q;
  logic [StepW-1:0] step_q;
  logic [CntW:0]    tb, tg, tr;

  assign tb = {rb_q, sb_q[SumW-1]};
  assign tg = {rg_q, sg_q[SumW-1]};
  assign tr = {rr_q, sr_q[SumW-1]};
  assign sts_o.div_last = step_q == StepW'(SumW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan && in_bounds;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lab_load) begin
      label_q <= rdata[PIX_W-1 -: CH_W];
      sb_q    <= '0;
      sg_q    <= '0;
      sr_q    <= '0;
      cnt_q   <= '0;
      rb_q    <= '0;
      rg_q    <= '0;
      rr_q    <= '0;
      dr_q    <= '0;
      dc_q    <= '0;
      step_q  <= '0;
    end else begin
      if (cmd_i.scan) begin
        if (dc_q == WinW'(Win - 1)) begin
          dc_q <= '0;
          dr_q <= dr_q + WinW'(1);
        end else begin
          dc_q <= dc_q + WinW'(1);
        end
      end
      if (rd_valid_q && rdata[PIX_W-1 -: CH_W] == label_q) begin
        sb_q  <= sb_q + SumW'(rdata[CH_W-1:0]);
        sg_q  <= sg_q + SumW'(rdata[2*CH_W-1 -: CH_W]);
        sr_q  <= sr_q + SumW'(rdata[3*CH_W-1 -: CH_W]);
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.div_step) begin
        step_q <= step_q + StepW'(1);
        if (tb >= (CntW + 1)'(cnt_q)) begin
          rb_q <= CntW'(tb - (CntW + 1)'(cnt_q));
          sb_q <= {sb_q[SumW-2:0], 1'b1};
        end else begin
          rb_q <= CntW'(tb);
          sb_q <= {sb_q[SumW-2:0], 1'b0};
        end
        if (tg >= (CntW + 1)'(cnt_q)) begin
          rg_q <= CntW'(tg - (CntW + 1)'(cnt_q));
          sg_q <= {sg_q[SumW-2:0], 1'b1};
        end else begin
          rg_q <= CntW'(tg);
          sg_q <= {sg_q[SumW-2:0], 1'b0};
        end
        if (tr >= (CntW + 1)'(cnt_q)) begin
          rr_q <= CntW'(tr - (CntW + 1)'(cnt_q));
          sr_q <= {sr_q[SumW-2:0], 1'b1};
        end else begin
          rr_q <= CntW'(tr);
          sr_q <= {sr_q[SumW-2:0], 1'b0};
        end
      end
    end
  end

  assign blue_o  = sb_q[CH_W-1:0];
  assign green_o = sg_q[CH_W-1:0];
  assign red_o   = sr_q[CH_W-1:0];
  assign last_o  = last_q;
endmodule

/* hw/rtl/label_masked_window_mean_core.sv */
// Top level of the label masked window mean core.
// Each pixel beat is written into a line store of 3*Radius+1 rows, since on narrow frames the
// newest pixel runs up to Radius rows past the window; once a centre is due, the controller
// reads the centre label, then scans the (2*Radius+1)^2 window through the single store port
// one entry per cycle, and a restoring divider produces the three means in parallel.
// A beat that yields no result leaves the controller idle; a beat that yields a result holds
// off the next beat through the label read, window scan, division and the wait for the result
// to be taken. A configuration write restarts the frame.
module label_masked_window_mean_core import lmwm_pkg::*; #(
  parameter int unsigned MaxWidth = 1024,
  parameter int unsigned Radius   = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  lmwm_pix_if.sink             pix_i,
  lmwm_mean_if.source          mean_o
);
  cmd_t cmd;
  sts_t sts;

  lmwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (mean_o.valid),
    .out_ready_i (mean_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmwm_dp #(.MaxWidth(MaxWidth), .Radius(Radius)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .op_i       (pix_i.operation),
    .pix_i      ({pix_i.segment_label, pix_i.red_in, pix_i.green_in, pix_i.blue_in}),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .blue_o     (mean_o.blue_mean),
    .green_o    (mean_o.green_mean),
    .red_o      (mean_o.red_mean),
    .last_o     (mean_o.frame_last)
  );
endmodule

/* verif/tb.sv */
// Self-checking testbench for the label masked window mean core.
module tb import lmwm_pkg::*; ();

  localparam int unsigned MAX_W      = 1024;
  localparam int unsigned RAD        = 5;
  localparam int unsigned RING_DEPTH = 2 * RAD * MAX_W + 2 * RAD + 1;
  localparam int unsigned IDLE_PCT   = 28;
  localparam int unsigned STALL_MAX  = 3000;
  localparam int unsigned SETTLE     = 200;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } mean_t;

  class mean_scoreboard;
    bit [31:0]   pixels [RING_DEPTH];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned width_reg;
    int unsigned height_reg;
    mean_t       pending[$];
    int unsigned errors;
    int unsigned results;

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
      if (idx == CFG_WIDTH) width_reg = v & 11'h7ff;
      else height_reg = v & 11'h7ff;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function mean_t window_mean(int unsigned centre, int unsigned w, int unsigned h);
      mean_t       m;
      int          cr;
      int          cc;
      int          rr;
      int          cl;
      bit [31:0]   px;
      bit [7:0]    lab;
      int unsigned sb;
      int unsigned sg;
      int unsigned sr;
      int unsigned cnt;
      cr  = centre / w;
      cc  = centre % w;
      lab = pixels[centre % RING_DEPTH][31:24];
      sb  = 0;
      sg  = 0;
      sr  = 0;
      cnt = 0;
      for (int dr = -int'(RAD); dr <= int'(RAD); dr++) begin
        rr = cr + dr;
        if (rr < 0 || rr >= int'(h)) continue;
        for (int dc = -int'(RAD); dc <= int'(RAD); dc++) begin
          cl = cc + dc;
          if (cl < 0 || cl >= int'(w)) continue;
          px = pixels[(rr * w + cl) % RING_DEPTH];
          if (px[31:24] != lab) continue;
          sb += px[7:0];
          sg += px[15:8];
          sr += px[23:16];
          cnt++;
        end
      end
      if (cnt == 0) cnt = 1;
      m.blue  = 8'(sb / cnt);
      m.green = 8'(sg / cnt);
      m.red   = 8'(sr / cnt);
      m.last  = 1'b0;
      return m;
    endfunction

    function void note_input(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             logic [7:0] lab);
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned lag;
      int unsigned pos;
      int unsigned centre;
      mean_t       m;
      w     = clamp(width_reg, MAX_W);
      h     = clamp(height_reg, MAX_HEIGHT);
      total = w * h;
      lag   = RAD * w + RAD;
      pos   = row_pos * w + col_pos;
      if (op == OP_DATA) begin
        if (pos >= total) return;
        pixels[pos % RING_DEPTH] = {lab, r, g, b};
      end else if (pos < total) begin
        return;
      end
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 11'h7ff;
      end
      if (pos < lag) return;
      centre = pos - lag;
      if (centre >= total) begin
        row_pos = 0;
        col_pos = 0;
        return;
      end
      m = window_mean(centre, w, h);
      if (centre == total - 1) begin
        m.last  = 1'b1;
        row_pos = 0;
        col_pos = 0;
      end
      pending.push_back(m);
    endfunction

    function void check(mean_t got);
      mean_t exp;
      results++;
      if (pending.size() == 0) begin
        $error("mean beat with no expectation pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.blue !== exp.blue) begin
        $error("blue_mean: expected %0d, got %0d", exp.blue, got.blue);
        errors++;
      end
      if (got.green !== exp.green) begin
        $error("green_mean: expected %0d, got %0d", exp.green, got.green);
        errors++;
      end
      if (got.red !== exp.red) begin
        $error("red_mean: expected %0d, got %0d", exp.red, got.red);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("frame_last: expected %0b, got %0b", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_data_i;

  lmwm_pix_if  pix ();
  lmwm_mean_if mean ();

  label_masked_window_mean_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .mean_o    (mean)
  );

  mean_scoreboard sb = new();
  bit             calm;
  int unsigned    beats_sent;
  int unsigned    noise_sent;
  int unsigned    frames_sent;
  int unsigned    stall_cnt;
  int unsigned    cur_w;
  int unsigned    cur_h;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean.ready <= 1'b0;
    end else begin
      if (mean.valid && mean.ready) begin
        sb.check('{mean.blue_mean, mean.green_mean, mean.red_mean, mean.frame_last});
      end
      mean.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pix.valid && pix.ready) || (mean.valid && mean.ready)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_MAX) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_beat(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                           logic [7:0] lab, bit noise);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid         <= 1'b1;
    pix.operation     <= op;
    pix.blue_in       <= b;
    pix.green_in      <= g;
    pix.red_in        <= r;
    pix.segment_label <= lab;
    do @(posedge clk_i); while (!pix.ready);
    sb.note_input(op, b, g, r, lab);
    if (noise) noise_sent++;
    else beats_sent++;
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_pixel(bit noise);
    logic [7:0] lab;
    lab = ($urandom_range(4) == 0) ? 8'($urandom()) : 8'($urandom_range(3) * 85);
    send_beat(OP_DATA, rand_chan(), rand_chan(), rand_chan(), lab, noise);
  endtask

  task automatic wait_results();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= REG_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h);
    wait_results();
    write_cfg(CFG_WIDTH, w);
    write_cfg(CFG_HEIGHT, h);
    cur_w = sb.clamp(w & 11'h7ff, MAX_W);
    cur_h = sb.clamp(h & 11'h7ff, MAX_HEIGHT);
  endtask

  task automatic send_frame(bit with_noise);
    int unsigned total;
    int unsigned cut;
    total = cur_w * cur_h;
    cut   = (with_noise && $urandom_range(9) == 0) ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < cut; i++) begin
      if (with_noise && $urandom_range(19) == 0) begin
        send_beat(OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      end
      send_pixel(1'b0);
    end
    if (cut < total) return;
    for (int unsigned i = 0; i < RAD * cur_w + RAD; i++) begin
      if (with_noise && $urandom_range(19) == 0) send_pixel(1'b1);
      send_beat(OP_FLUSH, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                8'($urandom()), 1'b0);
    end
    frames_sent++;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_WIDTH;
    cfg_data_i        <= '0;
    pix.valid         <= 1'b0;
    pix.operation     <= OP_DATA;
    pix.blue_in       <= '0;
    pix.green_in      <= '0;
    pix.red_in        <= '0;
    pix.segment_label <= '0;
    calm              = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A few pixels at the reset geometry, which are too early to yield a mean.
    for (int i = 0; i < 6; i++) send_pixel(1'b0);

    // Directed: single column, early flush, extreme values, data while draining.
    set_geometry(1, 3);
    send_beat(OP_FLUSH, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_beat(OP_DATA, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hff, 1'b0);
    send_beat(OP_DATA, 8'h01, 8'h80, 8'hfe, 8'h00, 1'b0);
    send_beat(OP_DATA, 8'h55, 8'haa, 8'h0f, 8'h00, 1'b1);
    for (int i = 0; i < int'(RAD * cur_w + RAD); i++) begin
      send_beat(OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    end
    set_geometry(2, 2);
    send_beat(OP_DATA, 8'hff, 8'h00, 8'hff, 8'h07, 1'b0);
    send_beat(OP_DATA, 8'h00, 8'hff, 8'h00, 8'h07, 1'b0);
    send_beat(OP_DATA, 8'hff, 8'hff, 8'h00, 8'h07, 1'b0);
    send_beat(OP_DATA, 8'h10, 8'h20, 8'h30, 8'h08, 1'b0);
    for (int i = 0; i < int'(RAD * cur_w + RAD); i++) begin
      send_beat(OP_FLUSH, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    end

    while (beats_sent < 250) begin
      set_geometry($urandom_range(1, 12), $urandom_range(1, 8));
      calm = (frames_sent == 1) || ($urandom_range(5) == 0);
      repeat ($urandom_range(1, 2)) send_frame(1'b1);
      calm = 1'b0;
    end

    // Out-of-range geometry: a clamped one-pixel frame, then partial frames at the
    // clamped tallest and widest geometry.
    set_geometry(0, 0);
    send_frame(1'b0);
    set_geometry(0, 11'h7ff);
    for (int i = 0; i < 30; i++) send_pixel(1'b0);
    set_geometry(11'h7ff, 1);
    for (int i = 0; i < 20; i++) send_pixel(1'b0);

    wait_results();
    $display("Sent %0d beats (%0d ignored), %0d complete frames, checked %0d means.",
             beats_sent + noise_sent, noise_sent, frames_sent, sb.results);
    $display("Small random frames plus partial frames at clamped 1024-wide and 1024-tall size.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
